/* design/rbs_pkg.sv */
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types, widths and helpers for the ray/box slab test.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int NUM_W = CW + FB;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_NEG_INF = 2'd0,
    CLS_FINITE  = 2'd1,
    CLS_POS_INF = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t          cls;
    logic [CW-1:0] key;
  } tval_t;

  // per axis sideband carried alongside the dividers
  typedef struct packed {
    logic ok;
    logic zero;
    logic dneg;
    logic nneg_near;
    logic nneg_far;
  } side_t;

  localparam logic [CW-1:0] SIGN_BIT = {1'b1, {(CW-1){1'b0}}};

  function automatic logic t_gt(tval_t a, tval_t b);
    return {a.cls, a.key} > {b.cls, b.key};
  endfunction

  function automatic tval_t sat_tval(logic [NUM_W-1:0] q, logic rneg);
    logic [NUM_W-1:0] limit;
    logic [CW-1:0]    qs;
    tval_t            r;
    limit = rneg ? NUM_W'(SIGN_BIT) : NUM_W'(SIGN_BIT - 1'b1);
    qs    = (q > limit) ? limit[CW-1:0] : q[CW-1:0];
    r.cls = CLS_FINITE;
    r.key = rneg ? SIGN_BIT - qs : SIGN_BIT + qs;
    return r;
  endfunction

endpackage

/* design/rbs_div.sv */
// ----------------------------------------------------------------------------
// rbs_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module rbs_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rbs_pkg::NUM_W-1:0]  num,
  input  logic [rbs_pkg::CW-1:0]     den,
  output logic [rbs_pkg::NUM_W-1:0]  quo
);
  import rbs_pkg::*;

  logic [NUM_W-1:0] num_s [NUM_W];
  logic [CW-1:0]    den_s [NUM_W];
  logic [CW-1:0]    rem_s [NUM_W];
  logic [NUM_W-1:0] q_s   [NUM_W];

  logic [NUM_W-1:0] num_in [NUM_W];
  logic [CW-1:0]    den_in [NUM_W];
  logic [CW-1:0]    rem_in [NUM_W];
  logic [NUM_W-1:0] q_in   [NUM_W];
  logic [CW:0]      trial  [NUM_W];
  logic             take   [NUM_W];

  always_comb begin
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        num_in[k] = num;
        den_in[k] = den;
        rem_in[k] = '0;
        q_in[k]   = '0;
      end else begin
        num_in[k] = num_s[k-1];
        den_in[k] = den_s[k-1];
        rem_in[k] = rem_s[k-1];
        q_in[k]   = q_s[k-1];
      end
      trial[k] = {rem_in[k], num_in[k][NUM_W-1-k]};
      take[k]  = trial[k] >= {1'b0, den_in[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_W; k++) begin
        num_s[k] <= num_in[k];
        den_s[k] <= den_in[k];
        rem_s[k] <= take[k] ? CW'(trial[k] - {1'b0, den_in[k]}) : trial[k][CW-1:0];
        q_s[k]   <= {q_in[k][NUM_W-2:0], take[k]};
      end
    end
  end

  assign quo = q_s[NUM_W-1];

endmodule

/* design/ray_box_slab_test.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Slab test of a stream of rays against one configured axis-aligned box.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes the six box bounds (index 0..5: min x,y,z, max x,y,z);
//   cfg_ready is always high, indexes above five are dropped. Write only
//   while no ray is in flight.
//   s_* carries one ray per item; m_* returns one hit bit per ray, in order.
//   Stages: 1 input stage, 48 divider stages (one quotient bit each for the
//   six parallel slab dividers), saturate, XY narrow, output register:
//   52 register stages.
//   Throughput: one ray per cycle while s_tready is high; the divider chain sets the depth.
//   A stalled output parks one result in a skid register; the pipeline keeps
//   moving until that register fills, then s_tready drops.
//   Reset clears the bounds to zero and all valid bits.
// ----------------------------------------------------------------------------
module ray_box_slab_test (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [rbs_pkg::IDX_W-1:0] cfg_index,
  input  logic [rbs_pkg::CW-1:0]   cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [6*rbs_pkg::CW-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // hit, zero pad
  output logic [7:0]               m_tdata
);
  import rbs_pkg::*;

  localparam int NDIV = 6;

  logic [CW-1:0] box_min [3];
  logic [CW-1:0] box_max [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_min[a] <= '0;
        box_max[a] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_X: box_min[0] <= cfg_data;
        REG_MIN_Y: box_min[1] <= cfg_data;
        REG_MIN_Z: box_min[2] <= cfg_data;
        REG_MAX_X: box_max[0] <= cfg_data;
        REG_MAX_Y: box_max[1] <= cfg_data;
        REG_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v, skid_hit, out_v, out_hit;

  assign en       = !skid_v;
  assign s_tready = en;

  // input stage
  logic [CW-1:0]    ob [3];
  logic [CW-1:0]    lb [3];
  logic [CW-1:0]    hb [3];
  logic [CW-1:0]    dr [3];
  logic [CW-1:0]    near_b [3];
  logic [CW-1:0]    far_b  [3];
  side_t            side_in [3];
  logic [CW-1:0]    dmag_in [3];
  logic [NUM_W-1:0] num_in  [NDIV];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ob[a] = s_tdata[a*CW +: CW] ^ SIGN_BIT;
      dr[a] = s_tdata[(a+3)*CW +: CW];
      lb[a] = box_min[a] ^ SIGN_BIT;
      hb[a] = box_max[a] ^ SIGN_BIT;
      side_in[a].dneg = dr[a][CW-1];
      dmag_in[a] = dr[a][CW-1] ? CW'(-dr[a]) : dr[a];
      side_in[a].zero = dr[a] == '0;
      side_in[a].ok   = (dr[a] != '0) || (lb[a] <= ob[a] && ob[a] <= hb[a]);
      near_b[a] = dr[a][CW-1] ? hb[a] : lb[a];
      far_b[a]  = dr[a][CW-1] ? lb[a] : hb[a];
      side_in[a].nneg_near = near_b[a] < ob[a];
      side_in[a].nneg_far  = far_b[a] < ob[a];
      num_in[2*a]   = NUM_W'(side_in[a].nneg_near ? ob[a] - near_b[a] : near_b[a] - ob[a]) << FB;
      num_in[2*a+1] = NUM_W'(side_in[a].nneg_far ? ob[a] - far_b[a] : far_b[a] - ob[a]) << FB;
    end
  end

  logic             v0;
  side_t            side0 [3];
  logic [CW-1:0]    dmag0 [3];
  logic [NUM_W-1:0] num0  [NDIV];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        side0[a] <= side_in[a];
        dmag0[a] <= dmag_in[a];
      end
      for (int i = 0; i < NDIV; i++) num0[i] <= num_in[i];
    end
  end

  // divider stages with sideband
  logic [NUM_W-1:0] quo [NDIV];

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    rbs_div u_div (
      .clk (clk),
      .en  (en),
      .num (num0[i]),
      .den (dmag0[i/2]),
      .quo (quo[i])
    );
  end

  logic  vd   [NUM_W];
  side_t sided [NUM_W][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_W; k++) vd[k] <= 1'b0;
    end else if (en) begin
      vd[0] <= v0;
      for (int k = 1; k < NUM_W; k++) vd[k] <= vd[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sided[0] <= side0;
      for (int k = 1; k < NUM_W; k++) sided[k] <= sided[k-1];
    end
  end

  // saturate
  side_t sd [3];
  tval_t tn_next [3];
  tval_t tx_next [3];

  always_comb begin
    sd = sided[NUM_W-1];
    for (int a = 0; a < 3; a++) begin
      if (sd[a].zero) begin
        tn_next[a].cls = CLS_NEG_INF;
        tn_next[a].key = '0;
        tx_next[a].cls = CLS_POS_INF;
        tx_next[a].key = '0;
      end else begin
        tn_next[a] = sat_tval(quo[2*a], sd[a].nneg_near ^ sd[a].dneg);
        tx_next[a] = sat_tval(quo[2*a+1], sd[a].nneg_far ^ sd[a].dneg);
      end
    end
  end

  logic  vs, ok_s;
  tval_t tn [3];
  tval_t tx [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (en) begin
      vs <= vd[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_s <= sd[0].ok && sd[1].ok && sd[2].ok;
      tn   <= tn_next;
      tx   <= tx_next;
    end
  end

  // narrow on x and y
  logic  vc, ok_c;
  tval_t tmin_c, tmax_c, tzn_c, tzx_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_c   <= ok_s && !t_gt(tn[0], tx[1]) && !t_gt(tn[1], tx[0]);
      tmin_c <= t_gt(tn[1], tn[0]) ? tn[1] : tn[0];
      tmax_c <= t_gt(tx[0], tx[1]) ? tx[1] : tx[0];
      tzn_c  <= tn[2];
      tzx_c  <= tx[2];
    end
  end

  // z check and output skid
  logic hit_next, produced;

  assign hit_next = ok_c && !t_gt(tmin_c, tzx_c) && !t_gt(tzn_c, tmax_c);
  assign produced = vc && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (!out_v || m_tready) begin
        out_v   <= 1'b1;
        out_hit <= skid_hit;
        skid_v  <= 1'b0;
      end
    end else if (!out_v || m_tready) begin
      out_v   <= produced;
      out_hit <= hit_next;
    end else if (produced) begin
      skid_v   <= 1'b1;
      skid_hit <= hit_next;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {7'b0, out_hit};

endmodule

/* design/rbs_checker.sv */
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks for ray_box_slab_test, bound to the top level.
// ----------------------------------------------------------------------------
module rbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_ready,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] == 7'd0 && cfg_ready))
    else $error("pad bits set or cfg stalled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled item changed");

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg_ready),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
